// ===== rtl/kms_pkg.sv =====
package kms_pkg;

  localparam logic [3:0] ROWS_ALL_HIGH = 4'hf;
  localparam logic [3:0] ROW1_LOW      = 4'h7;
  localparam logic [3:0] ROW2_LOW      = 4'hb;
  localparam logic [3:0] ROW3_LOW      = 4'hd;
  localparam logic [3:0] ROW4_LOW      = 4'he;
  localparam logic [1:0] LAST_COLUMN   = 2'd3;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd10;
  localparam logic       CFG_IDX_DEBOUNCE = 1'b0;

  // key table, column major, rows 1 to 4
  localparam logic [4:0] KEY_MAP [16] = '{
    5'd16, 5'd9,  5'd6,  5'd3,
    5'd0,  5'd8,  5'd5,  5'd2,
    5'd14, 5'd7,  5'd4,  5'd1,
    5'd13, 5'd14, 5'd15, 5'd16
  };

  typedef enum logic [3:0] {
    PH_SCAN       = 4'b0001,
    PH_PRESS_WAIT = 4'b0010,
    PH_HOLD       = 4'b0100,
    PH_HOLD_WAIT  = 4'b1000
  } kms_phase_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
  } kms_row_t;

  typedef struct packed {
    logic [3:0] column_drive;
    logic       pass_done;
    logic       key_found;
    logic [4:0] key_code;
  } kms_result_t;

  function automatic kms_row_t row_decode(input logic [3:0] rows);
    kms_row_t r;
    r = '{hit: 1'b1, idx: 2'd0};
    unique case (rows)
      ROW1_LOW: r.idx = 2'd0;
      ROW2_LOW: r.idx = 2'd1;
      ROW3_LOW: r.idx = 2'd2;
      ROW4_LOW: r.idx = 2'd3;
      default:  r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/kms_scan.sv =====
module kms_scan #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic [3:0]           rows,
  input  logic [15:0]          debounce,
  output kms_pkg::kms_result_t result
);
  import kms_pkg::*;

  localparam int CW = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;

  kms_phase_t              phase_r, phase_nxt;
  logic [1:0]              col_r, col_nxt;
  logic [COUNTER_BITS-1:0] cnt_r, cnt_nxt;
  logic [1:0]              row_r, row_nxt;
  logic [4:0]              key_r, key_nxt;
  logic                    seen_r, seen_nxt;

  logic [CW-1:0] cmax_w, deb_w, limit_w;
  logic          wait_over;
  logic          col_end, released;
  kms_row_t      dec;

  // wait saturates at the counter maximum
  assign cmax_w    = CW'({COUNTER_BITS{1'b1}});
  assign deb_w     = CW'(debounce);
  assign limit_w   = (deb_w < cmax_w) ? deb_w : cmax_w;
  assign wait_over = CW'(cnt_r) >= limit_w;
  assign dec       = row_decode(rows);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    row_nxt   = row_r;
    key_nxt   = key_r;
    seen_nxt  = seen_r;
    col_nxt   = col_r;
    col_end   = 1'b0;
    released  = 1'b0;
    result.column_drive = 4'hf & ~(4'h8 >> col_r);
    result.pass_done    = 1'b0;
    result.key_found    = 1'b0;
    result.key_code     = 5'd0;

    unique case (phase_r)
      PH_SCAN: begin
        if (rows == ROWS_ALL_HIGH) begin
          col_end = 1'b1;
        end else begin
          phase_nxt = PH_PRESS_WAIT;
          cnt_nxt   = '0;
        end
      end
      PH_PRESS_WAIT: begin
        if (!wait_over) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (dec.hit) begin
          row_nxt   = dec.idx;
          phase_nxt = PH_HOLD;
        end else begin
          col_end = 1'b1;
        end
      end
      PH_HOLD: begin
        if (rows == ROWS_ALL_HIGH) begin
          released = 1'b1;
        end else begin
          phase_nxt = PH_HOLD_WAIT;
          cnt_nxt   = '0;
        end
      end
      PH_HOLD_WAIT: begin
        if (!wait_over) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (dec.hit) begin
          phase_nxt = PH_HOLD;
        end else begin
          released = 1'b1;
        end
      end
      default: phase_nxt = PH_SCAN;
    endcase

    if (released) begin
      key_nxt  = KEY_MAP[{col_r, row_r}];
      seen_nxt = 1'b1;
      col_end  = 1'b1;
    end

    if (col_end) begin
      phase_nxt = PH_SCAN;
      cnt_nxt   = '0;
      row_nxt   = 2'd0;
      col_nxt   = col_r + 2'd1;
      if (col_r == LAST_COLUMN) begin
        result.pass_done = 1'b1;
        result.key_found = seen_nxt;
        result.key_code  = seen_nxt ? key_nxt : 5'd0;
        key_nxt  = 5'd0;
        seen_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SCAN;
      col_r   <= 2'd0;
      cnt_r   <= '0;
      row_r   <= 2'd0;
      key_r   <= 5'd0;
      seen_r  <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      cnt_r   <= cnt_nxt;
      row_r   <= row_nxt;
      key_r   <= key_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

// ===== rtl/keypad_matrix_scanner.sv =====
// channel  dir  signals                      contents
// in       in   in_tvalid/tready/tdata[7:0]  one tick with row levels
// out      out  out_tvalid/tready/tdata/     column drive, key code, pass end, key flag
//                tlast/tuser
// cfg      in   cfg_psel..cfg_prdata         debounce tick count
//
// one tick request is taken per cycle; its result appears the cycle after
// acceptance in the output register.
// a new request is taken while the output register drains in the same cycle,
// so throughput is one per cycle unless out_tready is held low.
// rst_n is synchronous; it clears the scan state and empties the output register.
// debounce resets to 10 ticks.
module keypad_matrix_scanner #(
  parameter int COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] row_levels
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] column_drive, [8:4] key_code
  output logic        out_tlast,  // pass_done
  output logic        out_tuser,  // key_found
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import kms_pkg::*;

  logic        in_acc;
  logic        out_valid_r;
  kms_result_t out_res_r;
  kms_result_t step_res;
  logic [15:0] debounce_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_DEBOUNCE) ? {16'd0, debounce_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == CFG_IDX_DEBOUNCE) begin
      debounce_r <= cfg_pwdata[15:0];
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  kms_scan #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (in_acc),
    .rows     (in_tdata[3:0]),
    .debounce (debounce_r),
    .result   (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.key_code, out_res_r.column_drive};
  assign out_tlast  = out_res_r.pass_done;
  assign out_tuser  = out_res_r.key_found;

endmodule

// ===== rtl/kms_chk.sv =====
module kms_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

  // exactly one column driven low
  a_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $countones(out_tdata[3:0]) == 3)
    else $error("column drive not one-cold");

  // key fields only at the end of a pass
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tuser && out_tdata[8:4] == 5'd0)
    else $error("key reported outside pass end");

  // pass end comes on the last column
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[3:0] == 4'he)
    else $error("pass end on wrong column");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[8:4] == 5'd0)
    else $error("key code without key");

endmodule

bind keypad_matrix_scanner kms_chk u_kms_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ===== tb/keypad_matrix_scanner_tb.sv =====
module keypad_matrix_scanner_tb;
  import kms_pkg::*;

  localparam int CNT_BITS = 16;
  localparam logic [2:0] ADDR_DEBOUNCE = {CFG_IDX_DEBOUNCE, 2'b00};

  // key codes, column major, rows 1 to 4
  localparam logic [4:0] KEYPAD_CODES [16] = '{
    5'd16, 5'd9,  5'd6,  5'd3,
    5'd0,  5'd8,  5'd5,  5'd2,
    5'd14, 5'd7,  5'd4,  5'd1,
    5'd13, 5'd14, 5'd15, 5'd16
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [3:0] row_levels
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;   // [3:0] column_drive, [8:4] key_code
  logic        out_tlast;   // pass_done
  logic        out_tuser;   // key_found
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // scanner state as predicted
  logic [15:0] debounce = DEBOUNCE_RESET;
  logic [1:0]  col_idx = 2'd0;
  kms_phase_t  phase = PH_SCAN;
  longint      wait_cnt = 0;
  logic [2:0]  cap_row = 3'd0;
  logic [4:0]  pass_code = 5'd0;
  logic        pass_seen = 1'b0;

  kms_result_t expected_scan_results [$];

  int  errors = 0;
  int  ticks_sent = 0;
  int  passes_seen = 0;
  int  key_passes_seen = 0;
  int  hold_off = 0;
  bit  quiet = 1'b0;

  keypad_matrix_scanner #(
    .COUNTER_BITS(CNT_BITS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [2:0] low_row_number(input logic [3:0] rows);
    case (rows)
      ROW1_LOW: return 3'd1;
      ROW2_LOW: return 3'd2;
      ROW3_LOW: return 3'd3;
      ROW4_LOW: return 3'd4;
      default:  return 3'd0;
    endcase
  endfunction

  function automatic longint wait_limit();
    longint cmax;
    cmax = (longint'(1) << CNT_BITS) - 1;
    return (longint'(debounce) < cmax) ? longint'(debounce) : cmax;
  endfunction

  // advances the predicted scanner by one tick and returns its result
  function automatic kms_result_t step_scanner(input logic [3:0] rows);
    kms_result_t res;
    logic [1:0]  col;
    bit          col_end;
    bit          released;
    logic [2:0]  r;
    col = col_idx;
    col_end = 1'b0;
    released = 1'b0;
    res.column_drive = 4'hf & ~(4'b1000 >> col);
    res.pass_done = 1'b0;
    res.key_found = 1'b0;
    res.key_code = 5'd0;
    case (phase)
      PH_SCAN: begin
        if (rows == ROWS_ALL_HIGH) col_end = 1'b1;
        else begin
          phase = PH_PRESS_WAIT;
          wait_cnt = 0;
        end
      end
      PH_PRESS_WAIT: begin
        if (wait_cnt < wait_limit()) wait_cnt++;
        else begin
          r = low_row_number(rows);
          if (r != 3'd0) begin
            cap_row = r;
            phase = PH_HOLD;
          end else col_end = 1'b1;
        end
      end
      PH_HOLD: begin
        if (rows == ROWS_ALL_HIGH) released = 1'b1;
        else begin
          phase = PH_HOLD_WAIT;
          wait_cnt = 0;
        end
      end
      default: begin
        if (wait_cnt < wait_limit()) wait_cnt++;
        else if (low_row_number(rows) != 3'd0) phase = PH_HOLD;
        else released = 1'b1;
      end
    endcase
    if (released) begin
      pass_code = KEYPAD_CODES[{col, 2'(cap_row - 3'd1)}];
      pass_seen = 1'b1;
      col_end = 1'b1;
    end
    if (col_end) begin
      phase = PH_SCAN;
      wait_cnt = 0;
      cap_row = 3'd0;
      if (col == LAST_COLUMN) begin
        res.pass_done = 1'b1;
        res.key_found = pass_seen;
        res.key_code = pass_seen ? pass_code : 5'd0;
        pass_code = 5'd0;
        pass_seen = 1'b0;
      end
      col_idx = col + 2'd1;
    end
    return res;
  endfunction

  function automatic logic [3:0] any_single_low();
    case ($urandom_range(3))
      0:       return ROW1_LOW;
      1:       return ROW2_LOW;
      2:       return ROW3_LOW;
      default: return ROW4_LOW;
    endcase
  endfunction

  // mostly plausible key activity for the current phase, with some noise
  function automatic logic [3:0] pick_row_levels();
    int p;
    p = $urandom_range(99);
    case (phase)
      PH_SCAN:
        return (p < 45) ? ROWS_ALL_HIGH : (p < 90) ? any_single_low() : 4'($urandom);
      PH_HOLD:
        return (p < 50) ? ROWS_ALL_HIGH : (p < 85) ? any_single_low() : 4'($urandom);
      default: begin
        if (wait_cnt < wait_limit()) return 4'($urandom);
        return (p < 80) ? any_single_low() : 4'($urandom);
      end
    endcase
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic send_tick(input logic [3:0] rows);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 7) begin
      gap = $urandom_range(4, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, rows};
    do @(posedge clk); while (!in_tready);
    expected_scan_results.push_back(step_scanner(rows));
    ticks_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_scan_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // write then read back the debounce register
  task automatic set_debounce(input logic [15:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_DEBOUNCE;
    cfg_pwdata  <= {16'h0000, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    debounce = value;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {16'h0000, value})
      report($sformatf("debounce read back %h, wrote %h", cfg_prdata, value));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    kms_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_scan_results.size() == 0) begin
        report("result with no tick outstanding");
      end else begin
        want = expected_scan_results.pop_front();
        if (out_tdata[3:0] !== want.column_drive)
          report($sformatf("column_drive %h, want %h", out_tdata[3:0], want.column_drive));
        if (out_tlast !== want.pass_done)
          report($sformatf("pass_done %b, want %b", out_tlast, want.pass_done));
        if (out_tuser !== want.key_found)
          report($sformatf("key_found %b, want %b", out_tuser, want.key_found));
        if (out_tdata[8:4] !== want.key_code)
          report($sformatf("key_code %0d, want %0d", out_tdata[8:4], want.key_code));
        if (want.pass_done) passes_seen++;
        if (want.key_found) key_passes_seen++;
      end
    end
  end

  // receiver: random stalls, or a counted hold-off when requested
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off   <= hold_off - 1;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= 7);
    end
  end

  task automatic test_default_debounce();
    repeat (4) send_tick(ROWS_ALL_HIGH);
    send_tick(ROW1_LOW);
    repeat (10) send_tick(4'($urandom));
    send_tick(ROW1_LOW);
    send_tick(ROWS_ALL_HIGH);
    repeat (3) send_tick(ROWS_ALL_HIGH);
    wait_idle();
  endtask

  task automatic test_zero_debounce();
    set_debounce(16'd0);
    send_tick(ROWS_ALL_HIGH);
    // column 2 row 1 maps to code zero, held through one re-read
    send_tick(ROW1_LOW);
    send_tick(ROW1_LOW);
    send_tick(4'h0);
    send_tick(ROW3_LOW);
    send_tick(ROWS_ALL_HIGH);
    // two rows low is no key
    send_tick(4'h3);
    send_tick(4'h3);
    send_tick(ROWS_ALL_HIGH);
    repeat (3) send_tick(ROWS_ALL_HIGH);
    // all rows low during hold counts as release
    send_tick(ROW4_LOW);
    send_tick(ROW4_LOW);
    send_tick(4'h0);
    send_tick(4'h0);
    wait_idle();
  endtask

  // start a wait at the widest setting, then shorten it so the re-read comes
  task automatic test_long_debounce();
    set_debounce(16'hffff);
    send_tick(ROW3_LOW);
    repeat (40) send_tick(4'($urandom));
    wait_idle();
    set_debounce(16'd48);
    repeat (8) send_tick(4'($urandom));
    send_tick(ROW3_LOW);
    send_tick(ROWS_ALL_HIGH);
    repeat (3) send_tick(ROWS_ALL_HIGH);
    wait_idle();
  endtask

  task automatic test_backpressure();
    set_debounce(16'd1);
    hold_off = 120;
    quiet = 1'b1;
    repeat (40) send_tick(pick_row_levels());
    quiet = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_scans();
    logic [15:0] settings [6];
    settings = '{16'd0, 16'd1, 16'd3, 16'd2, 16'd37, 16'($urandom_range(9))};
    foreach (settings[i]) begin
      set_debounce(settings[i]);
      quiet = (i == 2);
      repeat (300) send_tick(pick_row_levels());
      quiet = 1'b0;
      wait_idle();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = 3'd0;
    cfg_pwdata  = 32'h0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_debounce();
    test_zero_debounce();
    test_long_debounce();
    test_backpressure();
    test_random_scans();

    wait_idle();
    repeat (5) @(posedge clk);
    $display("covered %0d row ticks and %0d pass reports, %0d of them with a key,",
             ticks_sent, passes_seen, key_passes_seen);
    $display("debounce settings from 0 to 65535, output stalls and a long hold-off");
    if (errors == 0) begin
      $display("[keypad_matrix_scanner] OK");
    end else begin
      $display("[keypad_matrix_scanner] ERROR");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("[keypad_matrix_scanner] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kms_pkg.sv
rtl/kms_scan.sv
rtl/keypad_matrix_scanner.sv
rtl/kms_chk.sv
tb/keypad_matrix_scanner_tb.sv
